@@ rtl/gregorian_date_difference_core_assert.svh @@
// Assertion macros shared by the RTL of the date difference core.
`ifndef GREGORIAN_DATE_DIFFERENCE_CORE_ASSERT_SVH
`define GREGORIAN_DATE_DIFFERENCE_CORE_ASSERT_SVH

// Checked on every rising clock edge while reset is released.
`define GDD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gdd assertion failed");

// Checked on every rising clock edge, reset included.
`define GDD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("gdd assertion failed");

`endif

@@ rtl/gdd_pkg.sv @@
// Types, constants and helper functions of the Gregorian date difference core.
package gdd_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 22;
  // shifted year: year + 400, minus 1 for Jan and Feb, up to 16783
  localparam int unsigned YyW     = 15;
  // quotient of a shifted year by 100, up to 167
  localparam int unsigned QW      = 8;
  // day number, up to about 6.1 million
  localparam int unsigned DnW     = 23;
  localparam int unsigned OffW    = 9;

  localparam int unsigned YearBias   = 400;
  localparam int unsigned DaysInYear = 365;
  // floor(x / 100) = (x * 5243) >> 19 for every x below 43690
  localparam int unsigned Div100Mul   = 5243;
  localparam int unsigned Div100Shift = 19;
  localparam int unsigned Div100ProdW = YyW + 13;

  localparam logic [StatusW-1:0] StatusOk        = 2'd0;
  localparam logic [StatusW-1:0] StatusFirstBad  = 2'd1;
  localparam logic [StatusW-1:0] StatusSecondBad = 2'd2;

  // one date after the first stage: raw fields plus the quotients it needs
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [YyW-1:0]    yy;
    logic [QW-1:0]     yy_q100;
    logic [QW-1:0]     year_q100;
  } gdd_prep_t;

  function automatic logic [QW-1:0] div100(input logic [YyW-1:0] x);
    logic [Div100ProdW-1:0] prod;
    prod = Div100ProdW'(x) * Div100ProdW'(Div100Mul);
    return prod[Div100Shift +: QW];
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days from March 1 to the first of the month (year starts in March)
  function automatic logic [OffW-1:0] month_offset(input logic [MonthW-1:0] m);
    logic [OffW-1:0] off;
    case (m)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

  function automatic gdd_prep_t prep(input logic [YearW-1:0] y,
                                     input logic [MonthW-1:0] m,
                                     input logic [DayW-1:0] d);
    gdd_prep_t p;
    p.year      = y;
    p.month     = m;
    p.day       = d;
    // Jan and Feb count as the end of the previous year
    p.yy        = YyW'(y) + YyW'(YearBias) - ((m <= 4'd2) ? YyW'(1) : YyW'(0));
    p.yy_q100   = div100(p.yy);
    p.year_q100 = div100(YyW'(y));
    return p;
  endfunction

  function automatic logic date_ok(input gdd_prep_t p);
    logic            r100_zero;
    logic            leap;
    logic [DayW-1:0] len;
    r100_zero = (p.year == YearW'(YearW'(p.year_q100) * YearW'(100)));
    leap      = ((p.year[1:0] == 2'd0) && !r100_zero) ||
                (r100_zero && (p.year_q100[1:0] == 2'd0));
    len       = month_len(p.month, leap);
    return (p.month >= 4'd1) && (p.month <= 4'd12) &&
           (p.day != '0) && (p.day <= len);
  endfunction

  // day number up to a constant offset, which cancels in the difference
  function automatic logic [DnW-1:0] day_number(input gdd_prep_t p);
    return DnW'(p.yy) * DnW'(DaysInYear) + DnW'(p.yy >> 2) - DnW'(p.yy_q100)
         + DnW'(p.yy_q100 >> 2) + DnW'(month_offset(p.month)) + DnW'(p.day);
  endfunction

endpackage

@@ rtl/gregorian_date_difference_core.sv @@
// Top level of the Gregorian date difference core: input register, one pass, result register.
//
// Input channel: in_valid_i / in_stall_o carry one beat holding two dates
// (year, month, day each). Output channel: out_valid_o / out_stall_i carry
// one result beat per input beat, in order: status_o (0 both dates valid,
// 1 first date bad, 2 second date bad) and day_count_o, the absolute day
// distance, zero when status_o is nonzero and saturated at 22 bits.
// A beat moves when valid is high and stall is low at a rising edge.
// From input beat to result beat lie the input register, then the date
// checks and day numbers in one combinational pass into the result
// register. Throughput is one beat per cycle while out_stall_i is low;
// each register loads whenever it is empty or the one after it moves, so
// a result waiting at the output does not keep the input side from
// taking a new beat until both registers are full.
// When out_stall_i is held, the result register holds its beat unchanged
// and in_stall_o rises once the input register has filled too.
// rst_ni (asynchronous, active low) empties both registers; no result is
// lost or repeated across a stall, and the core keeps no state between beats.
module gregorian_date_difference_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [gdd_pkg::YearW-1:0]     first_year_i,
  input  logic [gdd_pkg::MonthW-1:0]    first_month_i,
  input  logic [gdd_pkg::DayW-1:0]      first_day_i,
  input  logic [gdd_pkg::YearW-1:0]     second_year_i,
  input  logic [gdd_pkg::MonthW-1:0]    second_month_i,
  input  logic [gdd_pkg::DayW-1:0]      second_day_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gdd_pkg::StatusW-1:0]   status_o,
  output logic [gdd_pkg::CountW-1:0]    day_count_o
);
  import gdd_pkg::*;

  logic s1_vld_q, s2_vld_q;
  logic s1_en, s2_en;

  logic [YearW-1:0]  s1_y1_q, s1_y2_q;
  logic [MonthW-1:0] s1_m1_q, s1_m2_q;
  logic [DayW-1:0]   s1_d1_q, s1_d2_q;

  gdd_prep_t      p1, p2;
  logic           ok1, ok2;
  logic [DnW-1:0] dn1, dn2;

  logic [DnW-1:0]     diff;
  logic [StatusW-1:0] status_d, status_q;
  logic [CountW-1:0]  count_d, count_q;

  // a register loads when empty or when its contents move on
  assign s2_en = !s2_vld_q || !out_stall_i;
  assign s1_en = !s1_vld_q || s2_en;

  assign in_stall_o = !s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (s1_en) s1_vld_q <= in_valid_i;
      if (s2_en) s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_y1_q <= first_year_i;
      s1_m1_q <= first_month_i;
      s1_d1_q <= first_day_i;
      s1_y2_q <= second_year_i;
      s1_m2_q <= second_month_i;
      s1_d2_q <= second_day_i;
    end
    if (s2_en && s1_vld_q) begin
      status_q <= status_d;
      count_q  <= count_d;
    end
  end

  always_comb begin
    p1   = prep(s1_y1_q, s1_m1_q, s1_d1_q);
    p2   = prep(s1_y2_q, s1_m2_q, s1_d2_q);
    ok1  = date_ok(p1);
    ok2  = date_ok(p2);
    dn1  = day_number(p1);
    dn2  = day_number(p2);
    diff = (dn1 >= dn2) ? (dn1 - dn2) : (dn2 - dn1);
    if (!ok1) begin
      status_d = StatusFirstBad;
      count_d  = '0;
    end else if (!ok2) begin
      status_d = StatusSecondBad;
      count_d  = '0;
    end else begin
      status_d = StatusOk;
      // only out-of-range years can reach the top bit
      count_d  = diff[DnW-1] ? '1 : diff[CountW-1:0];
    end
  end

  assign out_valid_o = s2_vld_q;
  assign status_o    = status_q;
  assign day_count_o = count_q;

`include "gregorian_date_difference_core_assert.svh"

  `GDD_ASSERT(a_bad_date_zero, clk_i, rst_ni, s2_vld_q && status_q != StatusOk |-> count_q == '0)
  `GDD_ASSERT(a_status_code_known, clk_i, rst_ni, s2_vld_q |-> status_q <= StatusSecondBad)
  `GDD_ASSERT_ALWAYS(a_no_stall_when_drained, clk_i, !out_stall_i |-> !in_stall_o)
  `GDD_ASSERT(a_full_stall, clk_i, rst_ni, s1_vld_q && s2_vld_q && out_stall_i |-> in_stall_o)

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the Gregorian date difference core.
module testbench;
  import gdd_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomPerPhase = 170;
  localparam int unsigned MonthDays [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [YearW-1:0]  first_year;
    logic [MonthW-1:0] first_month;
    logic [DayW-1:0]   first_day;
    logic [YearW-1:0]  second_year;
    logic [MonthW-1:0] second_month;
    logic [DayW-1:0]   second_day;
  } date_pair_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CountW-1:0]  day_count;
  } distance_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid  = 1'b0;
  logic                in_stall;
  date_pair_t          in_pair   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [StatusW-1:0]  status;
  logic [CountW-1:0]   day_count;

  date_pair_t pairs_pending[$];
  distance_t  distance_expected[$];
  distance_t  distance_want;

  int unsigned send_idle_pct  = 35;
  int unsigned recv_stall_pct = 72;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;

  gregorian_date_difference_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .first_year_i  (in_pair.first_year),
    .first_month_i (in_pair.first_month),
    .first_day_i   (in_pair.first_day),
    .second_year_i (in_pair.second_year),
    .second_month_i(in_pair.second_month),
    .second_day_i  (in_pair.second_day),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .day_count_o   (day_count)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor
  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    if (m < 1 || m > 12) return 0;
    if (m == 2 && leap_year(y)) return 29;
    return MonthDays[m];
  endfunction

  function automatic bit date_valid(int unsigned y, int unsigned m, int unsigned d);
    return (m >= 1) && (m <= 12) && (d >= 1) && (d <= month_length(y, m));
  endfunction

  // serial day from a shifted epoch (March-based year, +400 years)
  function automatic int unsigned serial_day(int unsigned y, int unsigned m, int unsigned d);
    int unsigned yy;
    int unsigned mp;
    yy = y + 400 - ((m <= 2) ? 1 : 0);
    mp = (m + 9) % 12;
    return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + d - 1;
  endfunction

  function automatic distance_t predict_distance(date_pair_t p);
    distance_t   r;
    int unsigned a;
    int unsigned b;
    int unsigned diff;
    r = '0;
    if (!date_valid(p.first_year, p.first_month, p.first_day)) begin
      r.status = StatusFirstBad;
    end else if (!date_valid(p.second_year, p.second_month, p.second_day)) begin
      r.status = StatusSecondBad;
    end else begin
      a = serial_day(p.first_year, p.first_month, p.first_day);
      b = serial_day(p.second_year, p.second_month, p.second_day);
      diff = (a > b) ? a - b : b - a;
      if (diff > 32'h3FFFFF) diff = 32'h3FFFFF;
      r.status    = StatusOk;
      r.day_count = CountW'(diff);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic date_pair_t make_pair(int unsigned y1, int unsigned m1, int unsigned d1,
                                           int unsigned y2, int unsigned m2, int unsigned d2);
    date_pair_t p;
    p.first_year   = YearW'(y1);
    p.first_month  = MonthW'(m1);
    p.first_day    = DayW'(d1);
    p.second_year  = YearW'(y2);
    p.second_month = MonthW'(m2);
    p.second_day   = DayW'(d2);
    return p;
  endfunction

  function automatic void random_date(output int unsigned y, output int unsigned m,
                                      output int unsigned d);
    y = ($urandom_range(9) == 0) ? $urandom_range(16383) : $urandom_range(9999, 1);
    m = $urandom_range(12, 1);
    // month ends and leap days get extra weight
    if ($urandom_range(3) == 0) d = month_length(y, m);
    else d = $urandom_range(month_length(y, m), 1);
  endfunction

  function automatic date_pair_t random_pair();
    date_pair_t  p;
    logic [63:0] raw;
    int unsigned y1, m1, d1, y2, m2, d2;
    int unsigned step;
    raw = {$urandom, $urandom};
    p = raw[$bits(date_pair_t)-1:0];
    if ($urandom_range(99) < 80) begin
      random_date(y1, m1, d1);
      random_date(y2, m2, d2);
      if ($urandom_range(9) == 0) begin
        y2 = y1;
        m2 = m1;
        d2 = d1;
      end else if ($urandom_range(4) == 0) begin
        // nearby years: second date in the same year as the first or the one after
        step = $urandom_range(1);
        y2 = (y1 + step < 16384) ? y1 + step : y1;
      end
      if (!date_valid(y2, m2, d2)) d2 = month_length(y2, m2);
      p = make_pair(y1, m1, d1, y2, m2, d2);
    end
    return p;
  endfunction

  task automatic load_directed();
    pairs_pending.push_back(make_pair(1, 1, 1, 9999, 12, 31));
    pairs_pending.push_back(make_pair(9999, 12, 31, 1, 1, 1));
    pairs_pending.push_back(make_pair(2024, 2, 29, 2024, 2, 29));
    pairs_pending.push_back(make_pair(2000, 2, 29, 1900, 3, 1));
    pairs_pending.push_back(make_pair(1900, 2, 29, 2000, 1, 1));
    pairs_pending.push_back(make_pair(2023, 6, 15, 2023, 2, 29));
    pairs_pending.push_back(make_pair(2023, 0, 10, 2023, 5, 0));
    pairs_pending.push_back(make_pair(2023, 13, 1, 2023, 1, 1));
    pairs_pending.push_back(make_pair(2023, 1, 1, 2023, 15, 1));
    pairs_pending.push_back(make_pair(2023, 4, 31, 2023, 4, 30));
    pairs_pending.push_back(make_pair(2023, 4, 30, 2023, 4, 0));
    pairs_pending.push_back(make_pair(0, 2, 29, 1, 1, 1));
    pairs_pending.push_back(make_pair(0, 1, 1, 16383, 12, 31));
    pairs_pending.push_back(make_pair(16383, 12, 31, 0, 3, 1));
    pairs_pending.push_back(make_pair(2024, 12, 31, 2025, 1, 1));
    pairs_pending.push_back(make_pair(2024, 2, 28, 2024, 3, 1));
    pairs_pending.push_back(make_pair(16383, 2, 28, 16383, 3, 1));
    pairs_pending.push_back(make_pair(16000, 2, 29, 15999, 12, 31));
    pairs_pending.push_back(make_pair(16383, 2, 29, 16383, 15, 31));
    pairs_pending.push_back(make_pair(9999, 12, 31, 9999, 12, 31));
    pairs_pending.push_back(make_pair(5000, 7, 31, 8191, 8, 31));
  endtask

  task automatic wait_drained();
    while (pairs_pending.size() != 0 || in_valid || distance_expected.size() != 0)
      @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------- driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_pair  <= '0;
    end else begin
      if (in_valid && !in_stall) distance_expected.push_back(predict_distance(in_pair));
      if (!in_valid || !in_stall) begin
        if (pairs_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_pair  <= pairs_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (distance_expected.size() == 0) begin
          report_mismatch("unexpected result beat, status", 32'(status), 32'd0);
        end else begin
          distance_want = distance_expected.pop_front();
          if (status !== distance_want.status)
            report_mismatch("status", 32'(status), 32'(distance_want.status));
          if (day_count !== distance_want.day_count)
            report_mismatch("day_count", 32'(day_count), 32'(distance_want.day_count));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct  = 35;
    recv_stall_pct = 72;
    load_directed();
    repeat (RandomPerPhase) pairs_pending.push_back(random_pair());
    // the next phase is queued only once every result is back
    wait_drained();

    send_idle_pct  = 72;
    recv_stall_pct = 35;
    repeat (RandomPerPhase) pairs_pending.push_back(random_pair());
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (RandomPerPhase) pairs_pending.push_back(random_pair());
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
